>>> sv/mcw_pkg.sv
// shared types and constants for the match context line window
package mcw_pkg;

  // request kinds
  localparam logic REQ_LINE  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // configuration register indexes
  localparam logic CFG_BEFORE = 1'b0;
  localparam logic CFG_AFTER  = 1'b1;

  localparam int HANDLE_W = 32;
  localparam int LENGTH_W = 16;
  localparam int BEFORE_W = 5;
  localparam int AFTER_W  = 6;
  localparam int CFG_W    = 6;

  // input word
  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] line_handle;
    logic [LENGTH_W-1:0] line_length;
    logic                is_match;
  } mcw_req_t;

  // result word
  typedef struct packed {
    logic [HANDLE_W-1:0] out_handle;
    logic [LENGTH_W-1:0] out_length;
    logic                out_is_match_line;
    logic                last_of_window;
  } mcw_rsp_t;

  // one stored line record
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
  } mcw_line_t;

  // readout flags that travel alongside the ring read data
  typedef struct packed {
    logic valid;
    logic is_match;
    logic last;
  } mcw_tag_t;

endpackage

>>> sv/match_context_line_window.sv
// top level of the match context line window
//
// Collects line records (handle and length) around the first matching line.
// Input words are offered with start and taken at a clock edge where start is
// high and busy is low. A line word is stored in the ring in that cycle unless
// it does not match, no match is held and before_lines is zero; lines are
// taken one per cycle while busy is low. A flush word closes the window.
// When the window completes (after_lines trailing lines, a full ring, or a
// flush after a match) busy rises and stays high until every line in the
// window (1 to RING_DEPTH lines) is read out. The sequencer reads one ring
// entry per cycle through the single read port. The first word passes the
// sequencer's address register and the registered ring read, then one word
// per cycle, oldest first, each marked by result_valid for exactly one cycle.
// last_of_window marks the final word; busy is low from then on.
// Results cannot be held off. Configuration writes (cfg_we, cfg_index,
// cfg_data) take effect at once; the user must make them while the block is
// idle, as the block does not enforce it. Reset clears the window and both
// registers but not the ring, and no ring entry is read before it is written.
module match_context_line_window import mcw_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  mcw_req_t         req,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output logic             result_valid,
  output mcw_rsp_t         result
);

  localparam int PTR_W = $clog2(RING_DEPTH);

  logic [BEFORE_W-1:0] before_lines;
  logic [AFTER_W-1:0]  after_lines;
  logic                accept;
  logic                wr_en;
  logic [PTR_W-1:0]    wr_addr;
  mcw_line_t           wr_data;
  logic                rd_en;
  logic [PTR_W-1:0]    rd_addr;
  mcw_line_t           rd_data;
  mcw_tag_t            tag;

  assign accept = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      before_lines <= '0;
      after_lines  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BEFORE: before_lines <= cfg_data[BEFORE_W-1:0];
        CFG_AFTER:  after_lines  <= cfg_data[AFTER_W-1:0];
        default:    ;
      endcase
    end
  end

  mcw_ctrl #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req         (req),
    .before_lines(before_lines),
    .after_lines (after_lines),
    .busy        (busy),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .tag         (tag)
  );

  mcw_ring #(
    .RING_DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // result word from the ring read and its flags
  assign result_valid = tag.valid;
  assign result = '{out_handle:        rd_data.handle,
                    out_length:        rd_data.length,
                    out_is_match_line: tag.is_match,
                    last_of_window:    tag.last};

  // a result word only follows a readout cycle
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result word without a readout cycle");

  // the final word of a window leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_of_window |-> !busy)
    else $error("busy after the final word of a window");

  // readout ends only on the final word of a window
  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> result_valid && result.last_of_window)
    else $error("readout ended without the final word");

endmodule

>>> sv/mcw_ring.sv
// line record ring memory, one write and one registered read port
module mcw_ring import mcw_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  input  mcw_line_t                     wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output mcw_line_t                     rd_data
);

  mcw_line_t mem [RING_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/mcw_ctrl.sv
// window bookkeeping and readout sequencer for the match context window
module mcw_ctrl import mcw_pkg::*; #(
  parameter int RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  mcw_req_t                      req,
  input  logic [BEFORE_W-1:0]           before_lines,
  input  logic [AFTER_W-1:0]            after_lines,
  output logic                          busy,
  output logic                          wr_en,
  output logic [$clog2(RING_DEPTH)-1:0] wr_addr,
  output mcw_line_t                     wr_data,
  output logic                          rd_en,
  output logic [$clog2(RING_DEPTH)-1:0] rd_addr,
  output mcw_tag_t                      tag
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CMP_W = (CNT_W > BEFORE_W) ? CNT_W : BEFORE_W;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(RING_DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(RING_DEPTH);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + 1'b1;
  endfunction

  // advance a pointer by k places, k at most the depth
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                              input logic [CNT_W-1:0] k);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(k);
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[PTR_W-1:0];
  endfunction

  // window state
  logic [PTR_W-1:0]   wp, wp_next;
  logic [PTR_W-1:0]   rp, rp_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [AFTER_W-1:0] post, post_next;
  logic               mseen, mseen_next;
  logic [PTR_W-1:0]   mslot, mslot_next;

  // readout sequencer state
  logic               dumping;
  logic [PTR_W-1:0]   dpos;
  logic [CNT_W-1:0]   dleft;
  logic [PTR_W-1:0]   dslot;

  // window handed to the sequencer
  logic               emit;
  logic               clear;
  logic [PTR_W-1:0]   e_pos;
  logic [CNT_W-1:0]   e_cnt;
  logic [PTR_W-1:0]   e_slot;

  // helpers for one stored line
  logic               full;
  logic [PTR_W-1:0]   rp1;
  logic [CNT_W-1:0]   fill1;
  logic [CNT_W-1:0]   fill2;
  logic [CNT_W-1:0]   fill_inc;
  logic [AFTER_W-1:0] post_inc;

  assign busy    = dumping;
  assign wr_addr = wp;
  assign wr_data = '{handle: req.line_handle, length: req.line_length};
  assign rd_en   = dumping;
  assign rd_addr = dpos;

  // next window state for an accepted word
  always_comb begin
    full     = (fill == DEPTH_C);
    rp1      = full ? ptr_inc(rp) : rp;
    fill1    = full ? fill - 1'b1 : fill;
    fill2    = fill1 + 1'b1;
    fill_inc = fill + 1'b1;
    post_inc = post + 1'b1;

    wp_next    = wp;
    rp_next    = rp;
    fill_next  = fill;
    post_next  = post;
    mseen_next = mseen;
    mslot_next = mslot;
    wr_en      = 1'b0;
    emit       = 1'b0;
    clear      = 1'b0;
    e_pos      = rp;
    e_cnt      = fill;
    e_slot     = mslot;

    if (accept) begin
      if (req.req_type == REQ_FLUSH) begin
        emit  = mseen;
        clear = 1'b1;
      end else if (!mseen) begin
        if (req.is_match) begin
          // first match: store and mark it
          wr_en      = 1'b1;
          wp_next    = ptr_inc(wp);
          rp_next    = rp1;
          fill_next  = fill2;
          mslot_next = wp;
          mseen_next = 1'b1;
          e_pos      = rp1;
          e_cnt      = fill2;
          e_slot     = wp;
          if (after_lines == '0 || fill2 == DEPTH_C) begin
            emit  = 1'b1;
            clear = 1'b1;
          end
        end else if (before_lines == '0) begin
          // no leading context: drop everything held
          rp_next   = ptr_add(rp, fill);
          fill_next = '0;
        end else begin
          // leading context: store, then trim to before_lines
          wr_en   = 1'b1;
          wp_next = ptr_inc(wp);
          if (CMP_W'(fill2) > CMP_W'(before_lines)) begin
            rp_next   = ptr_add(rp1, CNT_W'(CMP_W'(fill2) - CMP_W'(before_lines)));
            fill_next = CNT_W'(before_lines);
          end else begin
            rp_next   = rp1;
            fill_next = fill2;
          end
        end
      end else begin
        // trailing context
        wr_en     = 1'b1;
        wp_next   = ptr_inc(wp);
        fill_next = fill_inc;
        post_next = post_inc;
        e_cnt     = fill_inc;
        if (post_inc >= after_lines || fill_inc == DEPTH_C) begin
          emit  = 1'b1;
          clear = 1'b1;
        end
      end

      if (clear) begin
        wp_next    = '0;
        rp_next    = '0;
        fill_next  = '0;
        post_next  = '0;
        mseen_next = 1'b0;
        mslot_next = '0;
      end
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      fill  <= '0;
      post  <= '0;
      mseen <= 1'b0;
      mslot <= '0;
    end else begin
      wp    <= wp_next;
      rp    <= rp_next;
      fill  <= fill_next;
      post  <= post_next;
      mseen <= mseen_next;
      mslot <= mslot_next;
    end
  end

  // readout sequencer, one ring read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dumping <= 1'b0;
    end else if (emit) begin
      dumping <= 1'b1;
    end else if (dumping && dleft == CNT_W'(1)) begin
      dumping <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      dpos  <= e_pos;
      dleft <= e_cnt;
      dslot <= e_slot;
    end else if (dumping) begin
      dpos  <= ptr_inc(dpos);
      dleft <= dleft - 1'b1;
    end
  end

  // flags aligned with the registered ring read
  always_ff @(posedge clk) begin
    if (rst) begin
      tag.valid <= 1'b0;
    end else begin
      tag.valid <= dumping;
    end
    tag.is_match <= (dpos == dslot);
    tag.last     <= (dleft == CNT_W'(1));
  end

endmodule
